// ===== hw/rtl/lcd_controller_timing_regs_defines.svh =====
// ---------------------------------------------------------------------------
// LCD controller timing and registers: assertion macros
// Shared assertion helpers; compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef LCD_CONTROLLER_TIMING_REGS_DEFINES_SVH
`define LCD_CONTROLLER_TIMING_REGS_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset
`define LCDTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included
`define LCDTR_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LCDTR_ASSERT(label, prop, msg)
`define LCDTR_ASSERT_ALL(label, prop, msg)
`endif

`endif

// ===== hw/rtl/lcdtr_pkg.sv =====
// ---------------------------------------------------------------------------
// LCD controller timing and registers: package
// Opcodes, register addresses, timing constants and shared types.
// ---------------------------------------------------------------------------
package lcdtr_pkg;

  // Request kinds carried on the input stream
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_e;

  // I/O register addresses (low byte)
  localparam logic [7:0] ADDR_LCDC = 8'h40;
  localparam logic [7:0] ADDR_STAT = 8'h41;
  localparam logic [7:0] ADDR_SCY  = 8'h42;
  localparam logic [7:0] ADDR_SCX  = 8'h43;
  localparam logic [7:0] ADDR_LY   = 8'h44;
  localparam logic [7:0] ADDR_LYC  = 8'h45;
  localparam logic [7:0] ADDR_BGP  = 8'h47;
  localparam logic [7:0] ADDR_OBP0 = 8'h48;
  localparam logic [7:0] ADDR_OBP1 = 8'h49;
  localparam logic [7:0] ADDR_WY   = 8'h4a;
  localparam logic [7:0] ADDR_WX   = 8'h4b;
  localparam logic [7:0] ADDR_VBK  = 8'h4f;
  localparam logic [7:0] ADDR_BCPS = 8'h68;
  localparam logic [7:0] ADDR_BCPD = 8'h69;
  localparam logic [7:0] ADDR_OCPS = 8'h6a;
  localparam logic [7:0] ADDR_OCPD = 8'h6b;

  // Reset values and fixed read patterns
  localparam logic [7:0] LCDC_RESET  = 8'h91;
  localparam logic [7:0] BGP_RESET   = 8'hfc;
  localparam logic [7:0] OBP_RESET   = 8'hff;
  localparam logic [7:0] UNMAPPED_RD = 8'hff;
  localparam logic [7:0] VBK_RD_MASK = 8'hfe;
  localparam logic [7:0] STAT_RD_MASK = 8'hf8;

  // Line timing
  localparam logic [7:0] LAST_LINE   = 8'd153;
  localparam logic [7:0] VBLANK_LINE = 8'd144;
  localparam logic [8:0] CLK_STEP    = 9'd4;
  localparam logic [8:0] CLK_MODE3   = 9'd80;
  localparam logic [8:0] CLK_MODE0   = 9'd248;
  localparam logic [8:0] CLK_LINE    = 9'd392;
  localparam logic [8:0] CLK_VBLINE  = 9'd456;

  // STAT mode codes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Palette RAM geometry
  localparam int unsigned PAL_DEPTH = 64;
  localparam int unsigned PAL_AW    = 6;

  // Control bundle from the register file to one palette port
  typedef struct packed {
    logic       rd_en;    // capture the data at the current index
    logic       sel_we;   // write the select register
    logic       data_we;  // write the data port
    logic [7:0] wdata;
  } pal_req_t;

endpackage

// ===== hw/rtl/lcdtr_pal_port.sv =====
// ---------------------------------------------------------------------------
// LCD controller palette port
// Select register with auto-increment and a 64-byte palette RAM.
// ---------------------------------------------------------------------------
module lcdtr_pal_port (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcdtr_pkg::pal_req_t req_i,
  output logic [7:0]         sel_o,     // select register value
  output logic [7:0]         rd_data_o  // data captured at the last rd_en
);

  logic [7:0]                          sel_q, sel_d;
  logic [lcdtr_pkg::PAL_DEPTH-1:0]     valid_q;
  logic [7:0]                          ram [lcdtr_pkg::PAL_DEPTH];
  logic [7:0]                          rd_data_q;
  logic                                rd_valid_q;
  logic [lcdtr_pkg::PAL_AW-1:0]        pos;

  assign pos = sel_q[lcdtr_pkg::PAL_AW-1:0];

  // Select register: direct write, or bump after a data write in auto mode
  always_comb begin
    sel_d = sel_q;
    if (req_i.sel_we) begin
      sel_d = req_i.wdata;
    end else if (req_i.data_we && sel_q[7]) begin
      sel_d = {1'b1, 1'b0, pos + 6'd1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= '0;
      valid_q <= '0;
    end else begin
      sel_q <= sel_d;
      if (req_i.data_we) begin
        valid_q[pos] <= 1'b1;
      end
    end
  end

  // Palette RAM: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.data_we) begin
      ram[pos] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (req_i.rd_en) begin
      rd_valid_q <= valid_q[pos];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= ram[pos];
    end
  end

  // Entries never written read as zero
  assign sel_o     = sel_q;
  assign rd_data_o = rd_valid_q ? rd_data_q : 8'h00;

endmodule

// ===== hw/rtl/lcd_controller_timing_regs.sv =====
// ---------------------------------------------------------------------------
// LCD controller timing and register file
// Line clock, LY/STAT timing with interrupts, and the LCD I/O registers.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser holds the opcode (tick of four
//   dot clocks, register read, register write), tdata the register address
//   and the write byte. Each request yields exactly one result on m_axis:
//   the read byte plus the STAT and vblank interrupt flags raised by a tick.
//   cfg_we_i/cfg_wdata_i set the color-mode flag; write it only while idle.
// Timing and throughput:
//   A result appears in the cycle after its request is taken; one request per
//   cycle is sustained while m_axis takes each result. The state update and
//   result are computed in the accepting cycle and held in the output
//   register; palette data comes from a registered read of the palette RAM.
// Reset:
//   All registers return to their power-on values; the palette RAMs read
//   as zero until written (per-entry valid bits, no clearing pass).
// Stall:
//   While a result waits on m_axis, s_axis_tready stays low unless the
//   result is taken in the same cycle.
// ---------------------------------------------------------------------------
`include "lcd_controller_timing_regs_defines.svh"

module lcd_controller_timing_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // cgb_mode
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] reg_addr, [15:8] write_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] lcdc_irq,
                                      // [9] vblank_irq, [15:10] zero
);

  // Result source for read_data
  typedef enum logic [2:0] {
    SRC_REG = 3'b001,
    SRC_BGD = 3'b010,
    SRC_OBD = 3'b100
  } rd_src_e;

  logic       accept;
  logic [1:0] op;
  logic [7:0] addr, wdata;
  logic       cgb_q;

  logic [7:0] lcdc_q, lcdc_d, stat_q, stat_d, scy_q, scy_d, scx_q, scx_d;
  logic [7:0] ly_q, ly_d, lyc_q, lyc_d, bgp_q, bgp_d, obp0_q, obp0_d;
  logic [7:0] obp1_q, obp1_d, wy_q, wy_d, wx_q, wx_d;
  logic [8:0] dot_q, dot_d, dot_add;
  logic [1:0] mode_q, mode_d;
  logic       vbk_q, vbk_d;
  logic [7:0] ly_inc, ly_new;
  logic       line_step, stat_irq, vb_irq;
  logic [7:0] rd_val;
  rd_src_e    src_d, src_q;

  logic       out_valid_q;
  logic [7:0] rd_q;
  logic       stat_irq_q, vb_irq_q;

  lcdtr_pkg::pal_req_t bg_req, obj_req;
  logic [7:0] bg_sel, obj_sel, bg_rd, obj_rd;

  assign op    = s_axis_tuser;
  assign addr  = s_axis_tdata[7:0];
  assign wdata = s_axis_tdata[15:8];

  // Output register empties or drains this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Color-mode configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cgb_q <= 1'b0;
    end else if (cfg_we_i) begin
      cgb_q <= cfg_wdata_i;
    end
  end

  // Tick timing and register writes
  assign dot_add = dot_q + lcdtr_pkg::CLK_STEP;
  assign ly_inc  = ly_q + 8'd1;
  assign ly_new  = (ly_inc > lcdtr_pkg::LAST_LINE) ? 8'd0 : ly_inc;

  always_comb begin
    lcdc_d = lcdc_q; stat_d = stat_q; scy_d = scy_q; scx_d = scx_q;
    ly_d = ly_q; lyc_d = lyc_q; bgp_d = bgp_q; obp0_d = obp0_q;
    obp1_d = obp1_q; wy_d = wy_q; wx_d = wx_q; dot_d = dot_q;
    mode_d = mode_q; vbk_d = vbk_q;
    line_step = 1'b0;
    stat_irq  = 1'b0;
    vb_irq    = 1'b0;
    unique case (op)
      lcdtr_pkg::OP_TICK: begin
        if (lcdc_q[7]) begin
          dot_d = dot_add;
          if (ly_q >= lcdtr_pkg::VBLANK_LINE) begin
            line_step = (dot_add >= lcdtr_pkg::CLK_VBLINE);
          end else if (dot_add == lcdtr_pkg::CLK_MODE3) begin
            mode_d = lcdtr_pkg::MODE_XFER;
          end else if (dot_add == lcdtr_pkg::CLK_MODE0) begin
            mode_d   = lcdtr_pkg::MODE_HBLANK;
            stat_irq = stat_q[3];
          end else if (dot_add == lcdtr_pkg::CLK_LINE) begin
            line_step = 1'b1;
          end
          // new line: LYC compare, OAM or vblank entry
          if (line_step) begin
            dot_d = '0;
            ly_d  = ly_new;
            if (ly_new == lyc_q && stat_q[6]) begin
              stat_irq = 1'b1;
            end
            if (ly_new < lcdtr_pkg::VBLANK_LINE) begin
              mode_d = lcdtr_pkg::MODE_OAM;
              if (stat_q[5]) stat_irq = 1'b1;
            end else if (ly_new == lcdtr_pkg::VBLANK_LINE) begin
              mode_d = lcdtr_pkg::MODE_VBLANK;
              if (stat_q[4]) stat_irq = 1'b1;
              vb_irq = 1'b1;
            end
          end
        end
      end
      lcdtr_pkg::OP_WRITE: begin
        unique case (addr)
          lcdtr_pkg::ADDR_LCDC: begin
            if (lcdc_q[7] != wdata[7]) begin
              ly_d   = '0;
              mode_d = lcdtr_pkg::MODE_HBLANK;
              dot_d  = '0;
            end
            lcdc_d = wdata;
          end
          lcdtr_pkg::ADDR_STAT: stat_d = wdata;
          lcdtr_pkg::ADDR_SCY:  scy_d  = wdata;
          lcdtr_pkg::ADDR_SCX:  scx_d  = wdata;
          lcdtr_pkg::ADDR_LY:   ly_d   = wdata;
          lcdtr_pkg::ADDR_LYC:  lyc_d  = wdata;
          lcdtr_pkg::ADDR_BGP:  bgp_d  = wdata;
          lcdtr_pkg::ADDR_OBP0: obp0_d = wdata;
          lcdtr_pkg::ADDR_OBP1: obp1_d = wdata;
          lcdtr_pkg::ADDR_WY:   wy_d   = wdata;
          lcdtr_pkg::ADDR_WX:   wx_d   = wdata;
          lcdtr_pkg::ADDR_VBK:  if (cgb_q) vbk_d = wdata[0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Palette port requests
  always_comb begin
    bg_req.rd_en   = accept;
    bg_req.wdata   = wdata;
    bg_req.sel_we  = accept && op == lcdtr_pkg::OP_WRITE && cgb_q
                     && addr == lcdtr_pkg::ADDR_BCPS;
    bg_req.data_we = accept && op == lcdtr_pkg::OP_WRITE && cgb_q
                     && addr == lcdtr_pkg::ADDR_BCPD;
    obj_req.rd_en   = accept;
    obj_req.wdata   = wdata;
    obj_req.sel_we  = accept && op == lcdtr_pkg::OP_WRITE && cgb_q
                      && addr == lcdtr_pkg::ADDR_OCPS;
    obj_req.data_we = accept && op == lcdtr_pkg::OP_WRITE && cgb_q
                      && addr == lcdtr_pkg::ADDR_OCPD;
  end

  lcdtr_pal_port u_bg_pal (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (bg_req),
    .sel_o     (bg_sel),
    .rd_data_o (bg_rd)
  );

  lcdtr_pal_port u_obj_pal (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (obj_req),
    .sel_o     (obj_sel),
    .rd_data_o (obj_rd)
  );

  // Register read mux
  always_comb begin
    rd_val = lcdtr_pkg::UNMAPPED_RD;
    src_d  = SRC_REG;
    unique case (addr)
      lcdtr_pkg::ADDR_LCDC: rd_val = lcdc_q;
      lcdtr_pkg::ADDR_STAT: rd_val = (stat_q & lcdtr_pkg::STAT_RD_MASK)
                                     | {5'd0, (ly_q == lyc_q), mode_q};
      lcdtr_pkg::ADDR_SCY:  rd_val = scy_q;
      lcdtr_pkg::ADDR_SCX:  rd_val = scx_q;
      lcdtr_pkg::ADDR_LY:   rd_val = ly_q;
      lcdtr_pkg::ADDR_LYC:  rd_val = lyc_q;
      lcdtr_pkg::ADDR_BGP:  rd_val = bgp_q;
      lcdtr_pkg::ADDR_OBP0: rd_val = obp0_q;
      lcdtr_pkg::ADDR_OBP1: rd_val = obp1_q;
      lcdtr_pkg::ADDR_WY:   rd_val = wy_q;
      lcdtr_pkg::ADDR_WX:   rd_val = wx_q;
      lcdtr_pkg::ADDR_VBK:  if (cgb_q) rd_val = lcdtr_pkg::VBK_RD_MASK | {7'd0, vbk_q};
      lcdtr_pkg::ADDR_BCPS: if (cgb_q) rd_val = bg_sel;
      lcdtr_pkg::ADDR_BCPD: if (cgb_q) src_d = SRC_BGD;
      lcdtr_pkg::ADDR_OCPS: if (cgb_q) rd_val = obj_sel;
      lcdtr_pkg::ADDR_OCPD: if (cgb_q) src_d = SRC_OBD;
      default: ;
    endcase
    if (op != lcdtr_pkg::OP_READ) begin
      rd_val = 8'h00;
      src_d  = SRC_REG;
    end
  end

  // Register file and timing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcdc_q <= lcdtr_pkg::LCDC_RESET;
      stat_q <= '0;
      scy_q  <= '0;
      scx_q  <= '0;
      ly_q   <= '0;
      lyc_q  <= '0;
      bgp_q  <= lcdtr_pkg::BGP_RESET;
      obp0_q <= lcdtr_pkg::OBP_RESET;
      obp1_q <= lcdtr_pkg::OBP_RESET;
      wy_q   <= '0;
      wx_q   <= '0;
      dot_q  <= '0;
      mode_q <= lcdtr_pkg::MODE_HBLANK;
      vbk_q  <= 1'b0;
    end else if (accept) begin
      lcdc_q <= lcdc_d;
      stat_q <= stat_d;
      scy_q  <= scy_d;
      scx_q  <= scx_d;
      ly_q   <= ly_d;
      lyc_q  <= lyc_d;
      bgp_q  <= bgp_d;
      obp0_q <= obp0_d;
      obp1_q <= obp1_d;
      wy_q   <= wy_d;
      wx_q   <= wx_d;
      dot_q  <= dot_d;
      mode_q <= mode_d;
      vbk_q  <= vbk_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      src_q       <= SRC_REG;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
      if (s_axis_tvalid) begin
        src_q <= src_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q       <= rd_val;
      stat_irq_q <= stat_irq;
      vb_irq_q   <= vb_irq;
    end
  end

  logic [7:0] rd_out;
  always_comb begin
    unique case (src_q)
      SRC_BGD: rd_out = bg_rd;
      SRC_OBD: rd_out = obj_rd;
      default: rd_out = rd_q;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, vb_irq_q, stat_irq_q, rd_out};

  // Line clock only moves in steps of four
  `LCDTR_ASSERT(a_dot_aligned, dot_q[1:0] == 2'b00, "line clock misaligned")
  // With the LCD off and no request the line clock holds
  `LCDTR_ASSERT(a_dot_frozen, !lcdc_q[7] && !accept |=> $stable(dot_q),
                "line clock moved while LCD off")
  // A pending vblank result matches the state that raised it
  `LCDTR_ASSERT(a_vblank_state,
                out_valid_q && m_axis_tdata[9] |->
                ly_q == lcdtr_pkg::VBLANK_LINE && mode_q == lcdtr_pkg::MODE_VBLANK,
                "vblank interrupt without vblank state")
  // Nothing pending right after reset
  `LCDTR_ASSERT_ALL(a_reset_empty, !rst_ni |=> !out_valid_q || rst_ni,
                    "result pending out of reset")

endmodule
